>>> hw/rtl/pal_pkg.sv
// shared types and constants of the positional array list
`default_nettype none
package pal_pkg;

	// defaults for the top-level parameters
	localparam int CAPACITY_DEF   = 32;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed field widths of the transaction payloads
	localparam int POS_W  = 6;
	localparam int CNT_W  = 7;
	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_READ   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	// what each cell does in a cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_APPEND,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [CNT_W-1:0]   pos;
		logic [CNT_W-1:0]   count;
	} cell_cmd_t;

	typedef struct packed {
		req_kind_t                 req_type;
		logic [POS_W-1:0]          position;
		logic signed [WORD_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [WORD_W-1:0]  data_out;
		logic [POS_W-1:0]          index_out;
		logic [CNT_W-1:0]          count_out;
		logic                      last;
	} rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/pal_cell.sv
// one storage cell of the list chain
`default_nettype none
module pal_cell #(
	parameter int IDX        = 0,
	parameter int DATA_WIDTH = 32
) (
	input  wire                    clk,
	input  pal_pkg::cell_cmd_t     cmd,
	input  wire [DATA_WIDTH-1:0]   value,
	input  wire [DATA_WIDTH-1:0]   left,
	input  wire [DATA_WIDTH-1:0]   right,
	input  wire [DATA_WIDTH-1:0]   head,
	output logic [DATA_WIDTH-1:0]  data,
	output logic [DATA_WIDTH-1:0]  tap
);
	import pal_pkg::*;

	localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;
	logic                  hit;

	assign hit  = (IDX_C == cmd.pos);
	assign data = data_q;
	// removed word for a delete, zero when this cell is not addressed
	assign tap  = hit ? data_q : '0;

	// neighbor selection per operation
	always_comb begin
		data_d = data_q;
		case (cmd.op)
			CELL_APPEND: begin
				if (IDX_C == cmd.count) data_d = value;
			end
			CELL_INSERT: begin
				if (hit) data_d = value;
				else if (IDX_C > cmd.pos && IDX_C <= cmd.count) data_d = left;
			end
			CELL_DELETE: begin
				if (IDX_C >= cmd.pos && NEXT_C < cmd.count) data_d = right;
			end
			CELL_ROTATE: begin
				if (NEXT_C < cmd.count) data_d = right;
				else if (NEXT_C == cmd.count) data_d = head;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule
`default_nettype wire

>>> hw/rtl/positional_array_list.sv
// top level of the positional array list: control, count and the cell chain
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------
//  request   | start, busy (taken if     | req  (req_type, position,
//            | start && !busy)           |       value)
//  result    | rsp_valid, one cycle      | rsp  (status, data_out,
//            |                           |       index_out, count_out, last)
//
// append, insert, delete and every refused request: the result shows in the
// cycle after the request is taken.
// read all: busy is high from the cycle after the request while the state is read;
// results come one per cycle, the first later than an update result (state register first);
// the chain rotates one place per cycle and is back in order at the end.
// arst_n clears count and control; results cannot be held off by the receiver.
`default_nettype none
module positional_array_list #(
	parameter int CAPACITY   = pal_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  pal_pkg::req_t  req,
	output logic           busy,
	output logic           rsp_valid,
	output pal_pkg::rsp_t  rsp
);
	import pal_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	state_t                state_q, state_d;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         rd_q;
	logic                  accept;
	logic                  rd_last;
	logic [CNT_W-1:0]      cnt_ext;
	logic [CNT_W-1:0]      pos_ext;
	logic                  full;
	logic                  empty;
	logic                  pos_bad;

	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] val_st;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];
	logic [DATA_WIDTH-1:0] removed;
	logic [DATA_WIDTH-1:0] out_src;
	logic [WORD_W-1:0]     out_word;

	rsp_t                  rsp_d;
	logic                  rsp_valid_d;
	logic [CW-1:0]         count_d;

	assign accept  = start && !busy;
	assign cnt_ext = CNT_W'(count_q);
	assign pos_ext = CNT_W'(req.position);
	assign full    = (cnt_ext == CAP_C);
	assign empty   = (count_q == '0);
	assign pos_bad = (pos_ext >= cnt_ext);
	assign rd_last = (CW'(rd_q) == count_q - 1'b1);

	// stored form of the incoming word
	generate
		if (DATA_WIDTH >= WORD_W) begin : g_st_wide
			assign val_st = DATA_WIDTH'($unsigned(req.value));
		end else begin : g_st_narrow
			assign val_st = req.value[DATA_WIDTH-1:0];
		end
	endgenerate

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req.req_type == REQ_READ && !empty) state_d = ST_READ;
			end
			ST_READ: begin
				if (rd_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs: busy and the command broadcast to the cells
	always_comb begin
		busy      = 1'b0;
		cmd.op    = CELL_HOLD;
		cmd.pos   = pos_ext;
		cmd.count = cnt_ext;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_APPEND: if (!full) cmd.op = CELL_APPEND;
						REQ_INSERT: if (!full && !pos_bad) cmd.op = CELL_INSERT;
						REQ_DELETE: if (!empty && !pos_bad) cmd.op = CELL_DELETE;
						default:    cmd.op = CELL_HOLD;
					endcase
				end
			end
			ST_READ: begin
				busy   = 1'b1;
				cmd.op = CELL_ROTATE;
			end
			default: busy = 1'b0;
		endcase
	end

	// cell chain
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [DATA_WIDTH-1:0] left_w;
			logic [DATA_WIDTH-1:0] right_w;
			if (gi == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = cell_data[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_lastc
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = cell_data[gi+1];
			end
			pal_cell #(
				.IDX        (gi),
				.DATA_WIDTH (DATA_WIDTH)
			) u_cell (
				.clk   (clk),
				.cmd   (cmd),
				.value (val_st),
				.left  (left_w),
				.right (right_w),
				.head  (cell_data[0]),
				.data  (cell_data[gi]),
				.tap   (cell_tap[gi])
			);
		end
	endgenerate

	// one-hot pick of the removed word
	always_comb begin
		removed = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			removed = removed | cell_tap[i];
		end
	end

	// word source for the result, then its read form (sign-extended when narrower than a word)
	always_comb begin
		if (state_q == ST_READ) out_src = cell_data[0];
		else if (req.req_type == REQ_DELETE) out_src = removed;
		else out_src = val_st;
	end

	generate
		if (DATA_WIDTH >= WORD_W) begin : g_rd_wide
			assign out_word = out_src[WORD_W-1:0];
		end else begin : g_rd_narrow
			assign out_word = WORD_W'($signed(out_src));
		end
	endgenerate

	// result and count update
	always_comb begin
		rsp_valid_d     = 1'b0;
		count_d         = count_q;
		rsp_d.status    = STAT_DONE;
		rsp_d.data_out  = '0;
		rsp_d.index_out = '0;
		rsp_d.count_out = cnt_ext;
		rsp_d.last      = 1'b1;
		if (state_q == ST_READ) begin
			rsp_valid_d     = 1'b1;
			rsp_d.data_out  = out_word;
			rsp_d.index_out = POS_W'(rd_q);
			rsp_d.last      = rd_last;
		end else if (accept) begin
			rsp_valid_d = 1'b1;
			case (req.req_type)
				REQ_APPEND: begin
					if (full) begin
						rsp_d.status = STAT_FULL;
					end else begin
						count_d         = count_q + 1'b1;
						rsp_d.data_out  = out_word;
						rsp_d.index_out = POS_W'(count_q);
						rsp_d.count_out = CNT_W'(count_d);
					end
				end
				REQ_INSERT: begin
					if (full) begin
						rsp_d.status = STAT_FULL;
					end else if (pos_bad) begin
						rsp_d.status = STAT_RANGE;
					end else begin
						count_d         = count_q + 1'b1;
						rsp_d.data_out  = out_word;
						rsp_d.index_out = req.position;
						rsp_d.count_out = CNT_W'(count_d);
					end
				end
				REQ_DELETE: begin
					if (empty) begin
						rsp_d.status = STAT_EMPTY;
					end else if (pos_bad) begin
						rsp_d.status = STAT_RANGE;
					end else begin
						count_d         = count_q - 1'b1;
						rsp_d.data_out  = out_word;
						rsp_d.index_out = req.position;
						rsp_d.count_out = CNT_W'(count_d);
					end
				end
				default: begin
					// read all: only an empty list answers at once
					rsp_valid_d  = empty;
					rsp_d.status = STAT_EMPTY;
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_q      <= '0;
			rsp_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			rsp_valid <= rsp_valid_d;
			if (state_q == ST_READ && !rd_last) rd_q <= rd_q + 1'b1;
			else rd_q <= '0;
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		rsp <= rsp_d;
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(count_q) <= CAP_C)
		else $error("count above capacity");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type != REQ_READ) |=> (rsp_valid && rsp.last))
		else $error("update without a single final result");

	a_stream_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> busy)
		else $error("stream result while idle");

	a_read_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> rsp_valid)
		else $error("read cycle gave no result");

endmodule
`default_nettype wire

>>> tb/pal_list_check.sv
// result checker for the positional array list: predicts every transaction and compares
module pal_list_check #(
	parameter int CAPACITY   = pal_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire            busy,
	input  pal_pkg::req_t  req,
	input  wire            rsp_valid,
	input  pal_pkg::rsp_t  rsp,
	output int             mismatches,
	output int             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import pal_pkg::*;

	// shadow copy of the list
	logic signed [WORD_W-1:0] list_words [CAPACITY];
	int                       list_len;

	// results still owed by the block, oldest first
	rsp_t                     pending_results [$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
		list_len    = 0;
	end

	// one line per mismatch
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// words keep their low DATA_WIDTH bits and come back sign-extended
	function automatic logic signed [WORD_W-1:0] fit_word(input logic signed [WORD_W-1:0] v);
		int sh;
		sh = (DATA_WIDTH >= WORD_W) ? 0 : WORD_W - DATA_WIDTH;
		return (v <<< sh) >>> sh;
	endfunction

	// update the shadow list and queue the results one request causes
	task automatic apply_request(input req_t r);
		rsp_t e;
		int   i;
		int   p;
		e      = '0;
		e.last = 1'b1;
		p      = int'(r.position);
		case (r.req_type)
			REQ_APPEND: begin
				if (list_len >= CAPACITY) begin
					e.status    = STAT_FULL;
					e.count_out = CNT_W'(list_len);
				end else begin
					list_words[list_len] = fit_word(r.value);
					e.status    = STAT_DONE;
					e.data_out  = list_words[list_len];
					e.index_out = POS_W'(list_len);
					list_len++;
					e.count_out = CNT_W'(list_len);
				end
			end
			REQ_INSERT: begin
				if (list_len >= CAPACITY) begin
					e.status    = STAT_FULL;
					e.count_out = CNT_W'(list_len);
				end else if (p >= list_len) begin
					e.status    = STAT_RANGE;
					e.count_out = CNT_W'(list_len);
				end else begin
					for (i = list_len; i > p; i--) begin
						list_words[i] = list_words[i-1];
					end
					list_words[p] = fit_word(r.value);
					list_len++;
					e.status    = STAT_DONE;
					e.data_out  = list_words[p];
					e.index_out = POS_W'(p);
					e.count_out = CNT_W'(list_len);
				end
			end
			REQ_DELETE: begin
				if (list_len == 0) begin
					e.status = STAT_EMPTY;
				end else if (p >= list_len) begin
					e.status    = STAT_RANGE;
					e.count_out = CNT_W'(list_len);
				end else begin
					e.status    = STAT_DONE;
					e.data_out  = list_words[p];
					e.index_out = POS_W'(p);
					// only live entries move down
					for (i = p; i + 1 < list_len; i++) begin
						list_words[i] = list_words[i+1];
					end
					list_len--;
					e.count_out = CNT_W'(list_len);
				end
			end
			default: begin
				if (list_len == 0) begin
					e.status = STAT_EMPTY;
				end else begin
					// read all streams every entry in order
					for (i = 0; i < list_len; i++) begin
						e.status    = STAT_DONE;
						e.data_out  = list_words[i];
						e.index_out = POS_W'(i);
						e.count_out = CNT_W'(list_len);
						e.last      = (i + 1 == list_len);
						pending_results.push_back(e);
					end
					return;
				end
			end
		endcase
		pending_results.push_back(e);
	endtask

	// compare results, then take in a new request transaction
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			list_len = 0;
			pending_results.delete();
		end else begin
			if (rsp_valid === 1'b1) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing expected", rsp, '0);
				end else begin
					want = pending_results.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.data_out !== want.data_out)
						report_mismatch("data_out", rsp.data_out, want.data_out);
					if (rsp.index_out !== want.index_out)
						report_mismatch("index_out", rsp.index_out, want.index_out);
					if (rsp.count_out !== want.count_out)
						report_mismatch("count_out", rsp.count_out, want.count_out);
					if (rsp.last !== want.last)
						report_mismatch("last", rsp.last, want.last);
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				apply_request(req);
			end
		end
		outstanding = pending_results.size();
	end

endmodule

>>> tb/tb.sv
// testbench top for the positional array list: stimulus, run limit and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pal_pkg::*;

	localparam int CAP        = CAPACITY_DEF;
	localparam int DW         = DATA_WIDTH_DEF;
	localparam int RAND_ITEMS = 300;
	localparam int LIMIT      = 200000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic rsp_valid;
	rsp_t rsp;
	int   mismatches;
	int   outstanding;

	// stimulus-side view of the list length, used only to steer positions
	int   shadow_len;
	bit   idle_on;
	int   cycle_count;

	positional_array_list #(
		.CAPACITY   (CAP),
		.DATA_WIDTH (DW)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	pal_list_check #(
		.CAPACITY   (CAP),
		.DATA_WIDTH (DW)
	) i_list_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb failed");
		$finish;
	end

	// drive one request transaction at the falling edge, hold until taken
	task automatic send_req(input req_kind_t kind, input logic [POS_W-1:0] pos,
			input logic signed [WORD_W-1:0] val);
		int p;
		p = int'(pos);
		while (idle_on && $urandom_range(0, 99) < 22) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start        <= 1'b1;
		req.req_type <= kind;
		req.position <= pos;
		req.value    <= val;
		do @(posedge clk); while (busy !== 1'b0);
		case (kind)
			REQ_APPEND: if (shadow_len < CAP) shadow_len++;
			REQ_INSERT: if (shadow_len < CAP && p < shadow_len) shadow_len++;
			REQ_DELETE: if (shadow_len > 0 && p < shadow_len) shadow_len--;
			default: ;
		endcase
		@(negedge clk);
	endtask

	initial begin
		req_kind_t                kind;
		logic [POS_W-1:0]         pos;
		logic signed [WORD_W-1:0] val;
		int                       roll;
		int                       edge_hits;
		bit                       grow;

		start      = 1'b0;
		req        = '0;
		arst_n     = 1'b0;
		shadow_len = 0;
		idle_on    = 1'b1;
		grow       = 1'b1;
		edge_hits  = 0;

		// hold reset, then release it at a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// requests on an empty list
		send_req(REQ_READ,   6'd0,  32'sd0);
		send_req(REQ_DELETE, 6'd0,  32'sd0);
		send_req(REQ_INSERT, 6'd0,  32'sd5);

		// extremes of the data word
		send_req(REQ_APPEND, 6'd63, 32'sh7fffffff);
		send_req(REQ_APPEND, 6'd0,  32'sh80000000);
		send_req(REQ_APPEND, 6'd0,  32'sd0);
		send_req(REQ_APPEND, 6'd0,  -32'sd1);

		// insert at the head, the middle, at the count and far out of range
		send_req(REQ_INSERT, 6'd0,  32'sh12345678);
		send_req(REQ_INSERT, 6'd2,  32'sh5a5aa5a5);
		send_req(REQ_INSERT, POS_W'(shadow_len), 32'sh0badf00d);
		send_req(REQ_INSERT, 6'd63, 32'sh0badf00d);
		send_req(REQ_READ,   6'd0,  32'sd0);

		// delete out of range, at the tail, at the head and in the middle
		send_req(REQ_DELETE, 6'd63, 32'sd0);
		send_req(REQ_DELETE, POS_W'(shadow_len), 32'sd0);
		send_req(REQ_DELETE, POS_W'(shadow_len - 1), 32'sd0);
		send_req(REQ_DELETE, 6'd0,  32'sd0);
		send_req(REQ_DELETE, 6'd1,  32'sd0);
		send_req(REQ_READ,   6'd0,  32'sd0);

		// drain to empty
		while (shadow_len > 0) begin
			send_req(REQ_DELETE, 6'd0, 32'sd0);
		end
		send_req(REQ_READ, 6'd0, 32'sd0);

		// random part: the list swings between empty and full
		for (int n = 0; n < RAND_ITEMS; n++) begin
			idle_on = !(n >= 120 && n < 200);

			// dwell a few requests at full and at empty before turning around
			if (grow && shadow_len == CAP) begin
				edge_hits++;
				if (edge_hits > 3) begin
					grow      = 1'b0;
					edge_hits = 0;
				end
			end else if (!grow && shadow_len == 0) begin
				edge_hits++;
				if (edge_hits > 3) begin
					grow      = 1'b1;
					edge_hits = 0;
				end
			end

			roll = $urandom_range(0, 99);
			if (grow) begin
				kind = (roll < 40) ? REQ_APPEND : (roll < 75) ? REQ_INSERT :
					(roll < 90) ? REQ_DELETE : REQ_READ;
			end else begin
				kind = (roll < 10) ? REQ_APPEND : (roll < 25) ? REQ_INSERT :
					(roll < 85) ? REQ_DELETE : REQ_READ;
			end

			// mostly valid positions, some at the count, some anywhere
			roll = $urandom_range(0, 99);
			if (roll < 80)
				pos = (shadow_len > 0) ? POS_W'($urandom_range(0, shadow_len - 1)) : '0;
			else if (roll < 90)
				pos = POS_W'(shadow_len);
			else
				pos = POS_W'($urandom_range(0, 63));

			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				case ($urandom_range(0, 3))
					0: val = 32'sh7fffffff;
					1: val = 32'sh80000000;
					2: val = 32'sd0;
					default: val = -32'sd1;
				endcase
			end else begin
				val = $urandom;
			end

			// noise: fully random request
			if ($urandom_range(0, 99) < 8) begin
				kind = req_kind_t'($urandom_range(0, 3));
				pos  = POS_W'($urandom_range(0, 63));
			end

			send_req(kind, pos, val);
		end

		// let the last results drain
		start <= 1'b0;
		wait (outstanding == 0);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
